@@ src/sof_length_crc8_deframer_unit_assert.svh @@
// Assertion macros shared by the deframer modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef SOF_LENGTH_CRC8_DEFRAMER_UNIT_ASSERT_SVH
`define SOF_LENGTH_CRC8_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SLCD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/slcd_pkg.sv @@
package slcd_pkg;

    // Frame limits
    localparam int MAX_FRAME = 128;
    localparam int FILL_W    = $clog2(MAX_FRAME);

    // Marker and header bytes
    localparam logic [7:0] SOF_MARK = 8'h7E;
    localparam logic [7:0] HDR_A    = 8'hBF;
    localparam logic [7:0] HDR_B    = 8'hAF;

    // CRC-8 settings
    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] CRC_INIT   = 8'h02;
    localparam logic [7:0] CRC_XOROUT = 8'h02;

    // Result event codes
    localparam logic [2:0] EV_DROPPED    = 3'd0;
    localparam logic [2:0] EV_IN_FRAME   = 3'd1;
    localparam logic [2:0] EV_VALID      = 3'd2;
    localparam logic [2:0] EV_CRC_BAD    = 3'd3;
    localparam logic [2:0] EV_TOO_LONG   = 3'd4;
    localparam logic [2:0] EV_BAD_HEADER = 3'd5;
    localparam logic [2:0] EV_OVERRUN    = 3'd6;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Output tdata width (27 bits of fields, padded to whole bytes)
    localparam int M_DATA_W = 32;

    // Classification made by the front for one byte
    typedef enum logic [2:0] {
        KIND_DROP,
        KIND_DATA,
        KIND_END,
        KIND_TOO_LONG,
        KIND_BAD_HDR,
        KIND_OVERRUN
    } kind_t;

    // One classified byte travelling from front to back
    typedef struct packed {
        logic [7:0] byte_echo;
        logic [7:0] fill_count;
        kind_t      kind;
        logic [7:0] crc_calc;
        logic [7:0] crc_byte;
    } rec_t;

    // One byte of CRC-8, MSB first
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

@@ src/slcd_front.sv @@
module slcd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] rx_byte
    input  logic                q_full,
    output logic                push,
    output slcd_pkg::rec_t      push_rec
);

`include "sof_length_crc8_deframer_unit_assert.svh"

    logic [slcd_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic [7:0]                  len_reg, len_next;
    logic [7:0]                  crc_reg, crc_next;
    logic [7:0]                  crcb_reg, crcb_next;
    logic [7:0]                  last_reg, last_next;

    logic                        accept;
    logic [slcd_pkg::FILL_W-1:0] size;
    logic [7:0]                  len_new;
    logic [7:0]                  crc_upd;
    logic [8:0]                  fill9;
    logic [8:0]                  len9;
    logic                        hdr_ok;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign push     = accept;

    assign size    = fill_reg + slcd_pkg::FILL_W'(1);
    assign len_new = (fill_reg == slcd_pkg::FILL_W'(1)) ? s_tdata : len_reg;
    assign crc_upd = slcd_pkg::crc8_update(crc_reg, s_tdata);
    assign fill9   = 9'(fill_reg);
    assign len9    = {1'b0, len_new};
    assign hdr_ok  = (s_tdata == slcd_pkg::HDR_A) || (s_tdata == slcd_pkg::HDR_B);

    // Classify the byte and compute the next frame state
    always_comb
    begin
        fill_next = fill_reg;
        len_next  = len_reg;
        crc_next  = crc_reg;
        crcb_next = crcb_reg;
        last_next = last_reg;

        push_rec.byte_echo  = s_tdata;
        push_rec.fill_count = 8'(fill_reg);
        push_rec.kind       = slcd_pkg::KIND_DATA;
        push_rec.crc_calc   = crcb_reg ^ slcd_pkg::CRC_XOROUT;
        push_rec.crc_byte   = last_reg;

        priority if (fill_reg == '0 && s_tdata != slcd_pkg::SOF_MARK)
        begin
            // drop bytes outside a frame
            push_rec.kind       = slcd_pkg::KIND_DROP;
            push_rec.fill_count = 8'd0;
        end
        else if (fill9 >= 9'(slcd_pkg::MAX_FRAME - 1))
        begin
            // reject a frame that grows too long
            fill_next           = '0;
            len_next            = '0;
            crc_next            = slcd_pkg::CRC_INIT;
            crcb_next           = slcd_pkg::CRC_INIT;
            last_next           = '0;
            push_rec.kind       = slcd_pkg::KIND_TOO_LONG;
            push_rec.fill_count = 8'd0;
        end
        else if (fill_reg == slcd_pkg::FILL_W'(1) && s_tdata == slcd_pkg::SOF_MARK)
        begin
            // collapse a doubled start marker: hold state
            push_rec.fill_count = 8'(fill_reg);
        end
        else
        begin
            if (fill_reg != '0)
            begin
                crcb_next = crc_reg;
                crc_next  = crc_upd;
                last_next = s_tdata;
                len_next  = len_new;
            end

            priority if (fill_reg == slcd_pkg::FILL_W'(3) &&
                         ({1'b0, len_reg} > 9'(slcd_pkg::MAX_FRAME) || !hdr_ok))
            begin
                fill_next           = '0;
                len_next            = '0;
                crc_next            = slcd_pkg::CRC_INIT;
                crcb_next           = slcd_pkg::CRC_INIT;
                last_next           = '0;
                push_rec.kind       = slcd_pkg::KIND_BAD_HDR;
                push_rec.fill_count = 8'd0;
            end
            else if (fill_reg != '0 && fill9 > len9 + 9'd1)
            begin
                fill_next           = '0;
                len_next            = '0;
                crc_next            = slcd_pkg::CRC_INIT;
                crcb_next           = slcd_pkg::CRC_INIT;
                last_next           = '0;
                push_rec.kind       = slcd_pkg::KIND_OVERRUN;
                push_rec.fill_count = 8'd0;
            end
            else if (s_tdata == slcd_pkg::SOF_MARK && fill9 > 9'd3 && fill9 == len9 + 9'd1)
            begin
                // end marker at its expected place closes the frame
                fill_next           = '0;
                len_next            = '0;
                crc_next            = slcd_pkg::CRC_INIT;
                crcb_next           = slcd_pkg::CRC_INIT;
                last_next           = '0;
                push_rec.kind       = slcd_pkg::KIND_END;
                push_rec.fill_count = 8'(size);
            end
            else
            begin
                fill_next           = size;
                push_rec.fill_count = 8'(size);
            end
        end
    end

    // Advance frame state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            len_reg  <= '0;
            crc_reg  <= slcd_pkg::CRC_INIT;
            crcb_reg <= slcd_pkg::CRC_INIT;
            last_reg <= '0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
            len_reg  <= len_next;
            crc_reg  <= crc_next;
            crcb_reg <= crcb_next;
            last_reg <= last_next;
        end
    end

    `SLCD_ASSERT_SAME(a_fill_bound, 1'b1, fill9 <= 9'(slcd_pkg::MAX_FRAME - 1), "fill out of range")
    `SLCD_ASSERT_NEXT(a_dup_sof, accept && fill_reg == slcd_pkg::FILL_W'(1) && s_tdata == slcd_pkg::SOF_MARK, fill_reg == slcd_pkg::FILL_W'(1), "doubled marker changed fill")
    `SLCD_ASSERT_NEXT(a_end_clears, accept && push_rec.kind == slcd_pkg::KIND_END, fill_reg == '0 && crc_reg == slcd_pkg::CRC_INIT, "frame end did not clear state")

endmodule

@@ src/slcd_queue.sv @@
module slcd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  slcd_pkg::rec_t push_rec,
    output logic           full,
    input  logic           pop,
    output slcd_pkg::rec_t pop_rec,
    output logic           not_empty
);

`include "sof_length_crc8_deframer_unit_assert.svh"

    slcd_pkg::rec_t              entry_reg [slcd_pkg::Q_DEPTH];
    logic [slcd_pkg::Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [slcd_pkg::Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [slcd_pkg::Q_CW-1:0]   count_reg, count_next;

    assign full      = (count_reg == slcd_pkg::Q_CW'(slcd_pkg::Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_rec   = entry_reg[rd_ptr_reg];

    // Move pointers and count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + slcd_pkg::Q_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + slcd_pkg::Q_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + slcd_pkg::Q_CW'(1);
        else if (pop && !push)
            count_next = count_reg - slcd_pkg::Q_CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed request
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

    `SLCD_ASSERT_SAME(a_q_no_overflow, push, !full || pop, "push into full queue")

endmodule

@@ src/slcd_back.sv @@
module slcd_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          not_empty,
    input  slcd_pkg::rec_t                pop_rec,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [slcd_pkg::M_DATA_W-1:0] m_tdata
);

`include "sof_length_crc8_deframer_unit_assert.svh"

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [slcd_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                          load;
    logic [2:0]                    event_res;
    logic [7:0]                    crc_out;

    assign load = !m_tvalid_reg || m_tready;
    assign pop  = load && not_empty;

    // Turn the classified byte into a status result
    always_comb
    begin
        crc_out = 8'd0;
        unique case (pop_rec.kind)
            slcd_pkg::KIND_DROP:     event_res = slcd_pkg::EV_DROPPED;
            slcd_pkg::KIND_DATA:     event_res = slcd_pkg::EV_IN_FRAME;
            slcd_pkg::KIND_END:
            begin
                crc_out   = pop_rec.crc_calc;
                event_res = (pop_rec.crc_calc == pop_rec.crc_byte) ?
                            slcd_pkg::EV_VALID : slcd_pkg::EV_CRC_BAD;
            end
            slcd_pkg::KIND_TOO_LONG: event_res = slcd_pkg::EV_TOO_LONG;
            slcd_pkg::KIND_BAD_HDR:  event_res = slcd_pkg::EV_BAD_HEADER;
            slcd_pkg::KIND_OVERRUN:  event_res = slcd_pkg::EV_OVERRUN;
            default:                 event_res = slcd_pkg::EV_DROPPED;
        endcase

        m_tvalid_next = load ? not_empty : m_tvalid_reg;
        m_tdata_next  = pop ? {5'd0, crc_out, event_res, pop_rec.fill_count,
                               pop_rec.byte_echo}
                            : m_tdata_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    // Hold the result until taken
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `SLCD_ASSERT_SAME(a_crc_only_at_end, m_tvalid_reg && m_tdata_reg[18:16] != slcd_pkg::EV_VALID && m_tdata_reg[18:16] != slcd_pkg::EV_CRC_BAD, m_tdata_reg[26:19] == 8'd0, "crc field set outside frame end")
    `SLCD_ASSERT_NEXT(a_pop_loads, pop, m_tvalid_reg, "popped request not presented")

endmodule

@@ src/sof_length_crc8_deframer_unit.sv @@
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tdata[7:0]  rx_byte
// m_*      out  m_tvalid/m_tready  m_tdata[26:0] byte_echo, fill_count, event_res, crc_calc
//
// One byte per cycle while the queue is not full; every accepted byte gives exactly one result.
// The front classifies a byte and updates the frame state (CRC-8 unrolled
// over eight shift-xor steps) in the cycle it is accepted; the queue entry
// registers it, then the back loads the result register from the four-entry queue.
// Reset clears the frame state, the queue and the output valid; no clearing pass.
// A stalled output fills the queue; s_tready drops only when the queue is full.
module sof_length_crc8_deframer_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] byte_echo, [15:8] fill_count, [18:16] event_res, [26:19] crc_calc
    output logic [slcd_pkg::M_DATA_W-1:0] m_tdata
);

    logic           q_full;
    logic           push;
    slcd_pkg::rec_t push_rec;
    logic           pop;
    slcd_pkg::rec_t pop_rec;
    logic           not_empty;

    slcd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .push     (push),
        .push_rec (push_rec)
    );

    slcd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .full      (q_full),
        .pop       (pop),
        .pop_rec   (pop_rec),
        .not_empty (not_empty)
    );

    slcd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .pop_rec   (pop_rec),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

@@ verif/sof_length_crc8_deframer_unit_checker.sv @@
`timescale 1ns / 1ps

module sof_length_crc8_deframer_unit_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [7:0]                    s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [slcd_pkg::M_DATA_W-1:0] m_tdata,
    output int                            fail_count,
    output int                            pending_count
);

    typedef struct {
        logic [7:0] echo;
        logic [7:0] fill;
        logic [2:0] ev;
        logic [7:0] crc;
    } status_t;

    // Shadow copy of the frame state
    int unsigned fill;
    logic [7:0]  len_field;
    logic [7:0]  crc_run;
    logic [7:0]  crc_before;
    logic [7:0]  last_byte;

    status_t status_q[$];

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] r;
        r = c ^ b;
        repeat (8) r = r[7] ? ((r << 1) ^ slcd_pkg::CRC_POLY) : (r << 1);
        return r;
    endfunction

    function automatic void drop_frame();
        fill       = 0;
        len_field  = 8'd0;
        crc_run    = slcd_pkg::CRC_INIT;
        crc_before = slcd_pkg::CRC_INIT;
        last_byte  = 8'd0;
    endfunction

    // Work out the status for one received byte and advance the frame state
    function automatic status_t deframe_byte(input logic [7:0] x);
        status_t     r;
        int unsigned size;
        logic [7:0]  crc_snap;
        logic [7:0]  last_snap;
        size   = fill + 1;
        r.echo = x;
        r.fill = 8'd0;
        r.ev   = slcd_pkg::EV_IN_FRAME;
        r.crc  = 8'd0;
        if (fill == 0 && x != slcd_pkg::SOF_MARK)
        begin
            drop_frame();
            r.ev = slcd_pkg::EV_DROPPED;
        end
        else if (size > slcd_pkg::MAX_FRAME - 1)
        begin
            drop_frame();
            r.ev = slcd_pkg::EV_TOO_LONG;
        end
        else if (size == 2 && x == slcd_pkg::SOF_MARK)
        begin
            // collapse a doubled start marker
            r.fill = 8'(fill);
        end
        else
        begin
            crc_snap  = crc_before;
            last_snap = last_byte;
            if (fill == 1)
                len_field = x;
            if (fill >= 1)
            begin
                crc_before = crc_run;
                crc_run    = crc8_step(crc_run, x);
                last_byte  = x;
            end
            if (size == 4 && (len_field > slcd_pkg::MAX_FRAME ||
                              !(x == slcd_pkg::HDR_A || x == slcd_pkg::HDR_B)))
            begin
                drop_frame();
                r.ev = slcd_pkg::EV_BAD_HEADER;
            end
            else if (size > 1 && size - 2 > len_field)
            begin
                drop_frame();
                r.ev = slcd_pkg::EV_OVERRUN;
            end
            else if (x == slcd_pkg::SOF_MARK && size > 4 && size == len_field + 2)
            begin
                r.crc  = crc_snap ^ slcd_pkg::CRC_XOROUT;
                r.ev   = (r.crc == last_snap) ? slcd_pkg::EV_VALID : slcd_pkg::EV_CRC_BAD;
                r.fill = 8'(size);
                drop_frame();
            end
            else
            begin
                fill   = size;
                r.fill = 8'(size);
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Predict on each input request, compare on each output request
    always @(posedge clk or negedge rst_n)
    begin
        status_t want;
        if (!rst_n)
        begin
            drop_frame();
            status_q.delete();
            fail_count    = 0;
            pending_count <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                status_q.push_back(deframe_byte(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (status_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = status_q.pop_front();
                    check_field("byte_echo", want.echo, m_tdata[7:0]);
                    check_field("fill_count", want.fill, m_tdata[15:8]);
                    check_field("event_res", 8'(want.ev), 8'(m_tdata[18:16]));
                    check_field("crc_calc", want.crc, m_tdata[26:19]);
                end
            end
            pending_count <= status_q.size();
        end
    end

endmodule

@@ verif/sof_length_crc8_deframer_unit_tb.sv @@
`timescale 1ns / 1ps

module sof_length_crc8_deframer_unit_tb;

    localparam int FULL         = 1000;   // keep the whole frame
    localparam int ITEMS_PHASE  = 170;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_LIMIT  = 5000;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [7:0]                    s_tdata;    // [7:0] rx_byte
    logic                          m_tvalid;
    logic                          m_tready;
    // [7:0] byte_echo, [15:8] fill_count, [18:16] event_res, [26:19] crc_calc
    logic [slcd_pkg::M_DATA_W-1:0] m_tdata;

    int fail_count;
    int pending_count;
    int item_count;
    int src_idle_pct;
    int sink_stall_pct;
    logic pressure_req;
    logic pressure_done;

    sof_length_crc8_deframer_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sof_length_crc8_deframer_unit_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop for a hung run
    initial
    begin
        #6_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off while the sender keeps going
    initial
    begin
        m_tready      = 1'b0;
        pressure_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pressure_req && !pressure_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                pressure_done = 1'b1;
            end
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Builds the frame CRC the same way a transmitter would
    function automatic logic [7:0] frame_crc_step(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] r;
        r = c ^ b;
        for (int k = 0; k < 8; k++)
            r = r[7] ? ((r << 1) ^ slcd_pkg::CRC_POLY) : (r << 1);
        return r;
    endfunction

    // Offer one byte, with random idle cycles ahead of it, and hold until accepted
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Send a frame of length byte len; pay < 0 gives random payload, else a fixed byte.
    // Only the first keep bytes go out.
    task automatic send_frame(input int len, input logic [7:0] hdr, input bit crc_err,
                              input logic [7:0] end_byte, input int keep, input int pay);
        logic [7:0] fr[$];
        logic [7:0] crc;
        int         n;
        crc = slcd_pkg::CRC_INIT;
        fr.push_back(slcd_pkg::SOF_MARK);
        fr.push_back(8'(len));
        for (int p = 2; p < len; p++)
            fr.push_back(p == 3 ? hdr : (pay < 0 ? 8'($urandom_range(255)) : 8'(pay)));
        for (int p = 1; p < fr.size(); p++)
            crc = frame_crc_step(crc, fr[p]);
        crc = crc ^ slcd_pkg::CRC_XOROUT;
        if (crc_err)
            crc = crc ^ 8'($urandom_range(1, 255));
        fr.push_back(crc);
        fr.push_back(end_byte);
        n = (keep < fr.size()) ? keep : fr.size();
        for (int i = 0; i < n; i++)
            send_byte(fr[i]);
        item_count += n;
    endtask

    // Mostly good frames with random content, the rest noise and broken frames
    task automatic random_frame();
        int         sel;
        int         len;
        int         n;
        logic [7:0] hdr;
        sel = $urandom_range(99);
        len = ($urandom_range(14) == 0) ? $urandom_range(100, slcd_pkg::MAX_FRAME)
                                        : $urandom_range(4, 20);
        hdr = $urandom_range(1) ? slcd_pkg::HDR_A : slcd_pkg::HDR_B;
        if (sel < 65)
            send_frame(len, hdr, 1'b0, slcd_pkg::SOF_MARK, FULL, -1);
        else if (sel < 75)
            send_frame(len, hdr, 1'b1, slcd_pkg::SOF_MARK, FULL, -1);
        else if (sel < 83)
        begin
            n = $urandom_range(1, 4);
            repeat (n) send_byte(8'($urandom_range(255)));
            item_count += n;
        end
        else if (sel < 89)
            send_frame(len, hdr, 1'b0, slcd_pkg::SOF_MARK, $urandom_range(2, len + 1), -1);
        else if (sel < 94)
        begin
            if ($urandom_range(1))
                send_frame(len, 8'($urandom_range(255)), 1'b0, slcd_pkg::SOF_MARK, FULL, -1);
            else
                send_frame($urandom_range(slcd_pkg::MAX_FRAME + 1, 255), hdr, 1'b0,
                           slcd_pkg::SOF_MARK, $urandom_range(4, 8), -1);
        end
        else
        begin
            if ($urandom_range(1))
                send_frame(len, hdr, 1'b0, 8'($urandom_range(255)), FULL, -1);
            else
                send_frame($urandom_range(0, 3), hdr, 1'b0, slcd_pkg::SOF_MARK, FULL, -1);
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        int waited;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = 8'd0;
        pressure_req   = 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        item_count     = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: bytes outside a frame
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        // doubled start marker, then a good frame with zero payload
        send_byte(slcd_pkg::SOF_MARK);
        send_frame(5, slcd_pkg::HDR_A, 1'b0, slcd_pkg::SOF_MARK, FULL, 8'h00);
        // all-ones payload, second header value
        send_frame(6, slcd_pkg::HDR_B, 1'b0, slcd_pkg::SOF_MARK, FULL, 8'hFF);
        // start marker inside the payload is plain data
        send_frame(7, slcd_pkg::HDR_A, 1'b0, slcd_pkg::SOF_MARK, FULL, slcd_pkg::SOF_MARK);
        // CRC byte wrong
        send_frame(4, slcd_pkg::HDR_B, 1'b1, slcd_pkg::SOF_MARK, FULL, -1);
        // shortest length with the CRC byte in the header slot
        send_frame(3, slcd_pkg::HDR_A, 1'b0, slcd_pkg::SOF_MARK, FULL, -1);
        // bad header byte, then length above the limit
        send_frame(5, 8'h00, 1'b0, slcd_pkg::SOF_MARK, FULL, 8'h11);
        send_frame(255, slcd_pkg::HDR_A, 1'b0, slcd_pkg::SOF_MARK, 5, 8'h22);
        // missing end marker, and a zero length
        send_frame(5, slcd_pkg::HDR_B, 1'b0, 8'h00, FULL, -1);
        send_frame(0, slcd_pkg::HDR_A, 1'b0, slcd_pkg::SOF_MARK, 3, -1);
        // largest frame that fits, then two that grow too long
        send_frame(slcd_pkg::MAX_FRAME - 3, slcd_pkg::HDR_A, 1'b0, slcd_pkg::SOF_MARK,
                   FULL, -1);
        send_frame(slcd_pkg::MAX_FRAME - 1, slcd_pkg::HDR_B, 1'b0, slcd_pkg::SOF_MARK,
                   FULL, -1);
        send_frame(slcd_pkg::MAX_FRAME, slcd_pkg::HDR_A, 1'b0, slcd_pkg::SOF_MARK, FULL, -1);

        // Random phases: none, sender idle, receiver stalls, both
        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle_pct   = (ph == 1) ? 67 : (ph == 3) ? 24 : 0;
            sink_stall_pct = (ph == 2) ? 67 : (ph == 3) ? 24 : 0;
            if (ph == 0)
                pressure_req <= 1'b1;
            item_count = 0;
            while (item_count < ITEMS_PHASE)
                random_frame();
        end

        // Drain
        s_tvalid       <= 1'b0;
        sink_stall_pct = 0;
        waited         = 0;
        @(posedge clk);
        while (pending_count != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);

        if (fail_count == 0 && pending_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
